/* hw/rtl/bswm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bswm_pkg
// Shared sizes, operation codes and controller/datapath interface structs for
// the bounded stack word machine.
// ----------------------------------------------------------------------------
package bswm_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned VALUE_BITS = 20;
  localparam int unsigned IN_BITS    = 32;
  localparam int unsigned OP_BITS    = 3;
  localparam int unsigned ANS_BITS   = VALUE_BITS + 1;
  localparam int unsigned CNT_BITS   = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_BITS  = $clog2(DEPTH);

  localparam logic [OP_BITS-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DUP  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ADD  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SUB  = 3'd4;

  // Controller to datapath: one strobe per step of an item.
  typedef struct packed {
    logic accept;  // latch the item, apply restart
    logic exec;    // first step: decode op, push/dup done here
    logic oper;    // add/sub with second operand from memory
    logic load;    // refresh the cached top from memory
    logic emit;    // capture the result into the output register
  } cmd_t;

  // Datapath to controller: which step follows.
  typedef struct packed {
    logic exec_read;  // exec issued a memory read
    logic exec_oper;  // that read feeds an add/sub
    logic oper_read;  // failed add/sub with entries below must reload the top
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/bswm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bswm_ctrl
// Sequencer for one item at a time; owns both handshakes.
// ----------------------------------------------------------------------------
module bswm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bswm_pkg::stat_t stat_i,
  output bswm_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_OPER   = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.exec_read) begin
          state_d = stat_i.exec_oper ? ST_OPER : ST_LOAD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_OPER: begin
        cmd_o.oper = 1'b1;
        state_d    = stat_i.oper_read ? ST_LOAD : ST_FINISH;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> slot_free)
    else $error("result emitted over an untaken result");
  a_accept_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted item did not start execution");
  a_oper_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OPER) |-> $past(state_q == ST_EXEC))
    else $error("operand step without a preceding exec step");

endmodule
`default_nettype wire

/* hw/rtl/bswm_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bswm_dpath
// Stack memory, count, cached top, sticky error and the result register.
// ----------------------------------------------------------------------------
module bswm_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bswm_pkg::cmd_t                      cmd_i,
  output bswm_pkg::stat_t                          stat_o,
  input  wire logic [bswm_pkg::OP_BITS-1:0]        op_i,
  input  wire logic [bswm_pkg::IN_BITS-1:0]        value_i,
  input  wire logic                                restart_i,
  output logic [bswm_pkg::VALUE_BITS-1:0]          top_value_o,
  output logic                                     not_empty_o,
  output logic                                     error_o,
  output logic signed [bswm_pkg::ANS_BITS-1:0]     answer_o
);

  localparam int unsigned VB = bswm_pkg::VALUE_BITS;
  localparam int unsigned CB = bswm_pkg::CNT_BITS;
  localparam int unsigned AB = bswm_pkg::ADDR_BITS;

  logic [VB-1:0] mem [bswm_pkg::DEPTH];
  logic [VB-1:0] rd_q;
  logic [AB-1:0] rd_addr;

  logic [bswm_pkg::OP_BITS-1:0] op_q;
  logic [bswm_pkg::IN_BITS-1:0] val_q;
  logic [CB-1:0]                cnt_q, cnt_d;
  logic [VB-1:0]                top_q, top_d;
  logic                         err_q, err_d;

  logic [VB-1:0]                out_top_q;
  logic                         out_ne_q, out_err_q;
  logic [bswm_pkg::ANS_BITS-1:0] out_ans_q;

  logic [CB-1:0] cnt_m2, cnt_m3, cnt_p1;
  logic          full, empty, two_plus, three_plus, val_bad;
  logic [VB:0]   sum;
  logic [VB-1:0] diff, res;
  logic          res_bad;
  logic          we;
  logic [AB-1:0] wa;
  logic [VB-1:0] wd;
  logic          ne;

  assign cnt_m2     = cnt_q - CB'(2);
  assign cnt_m3     = cnt_q - CB'(3);
  assign cnt_p1     = cnt_q + CB'(1);
  assign full       = (cnt_q == CB'(bswm_pkg::DEPTH));
  assign empty      = (cnt_q == '0);
  assign two_plus   = (cnt_q >= CB'(2));
  assign three_plus = (cnt_q >= CB'(3));
  assign val_bad    = ((val_q >> VB) != '0);

  // top is a, next (from memory) is b
  assign sum  = {1'b0, top_q} + {1'b0, rd_q};
  assign diff = top_q - rd_q;
  always_comb begin
    if (op_q == bswm_pkg::OP_SUB) begin
      res     = diff;
      res_bad = (top_q < rd_q);
    end else begin
      res     = sum[VB-1:0];
      res_bad = sum[VB];
    end
  end

  always_comb begin
    stat_o.exec_read = 1'b0;
    stat_o.exec_oper = 1'b0;
    case (op_q)
      bswm_pkg::OP_POP: begin
        stat_o.exec_read = two_plus;
      end
      bswm_pkg::OP_ADD, bswm_pkg::OP_SUB: begin
        stat_o.exec_read = two_plus;
        stat_o.exec_oper = two_plus;
      end
      default: begin
      end
    endcase
    stat_o.oper_read = res_bad && three_plus;
  end

  assign rd_addr = cmd_i.oper ? cnt_m3[AB-1:0] : cnt_m2[AB-1:0];

  // next state of count, top, error and the memory write
  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    err_d = err_q;
    we    = 1'b0;
    wa    = cnt_q[AB-1:0];
    wd    = top_q;
    if (cmd_i.accept && restart_i) begin
      cnt_d = '0;
      err_d = 1'b0;
    end
    if (cmd_i.exec) begin
      case (op_q)
        bswm_pkg::OP_PUSH: begin
          if (val_bad || full) begin
            err_d = 1'b1;
          end else begin
            we    = 1'b1;
            wd    = val_q[VB-1:0];
            top_d = val_q[VB-1:0];
            cnt_d = cnt_p1;
          end
        end
        bswm_pkg::OP_DUP: begin
          if (empty || full) begin
            err_d = 1'b1;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_p1;
          end
        end
        bswm_pkg::OP_POP: begin
          if (empty) begin
            err_d = 1'b1;
          end else begin
            cnt_d = cnt_q - CB'(1);
          end
        end
        bswm_pkg::OP_ADD, bswm_pkg::OP_SUB: begin
          if (!two_plus) begin
            err_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.oper) begin
      if (res_bad) begin
        err_d = 1'b1;
        cnt_d = cnt_m2;
      end else begin
        we    = 1'b1;
        wa    = cnt_m2[AB-1:0];
        wd    = res;
        top_d = res;
        cnt_d = cnt_q - CB'(1);
      end
    end
    if (cmd_i.load) begin
      top_d = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  assign ne = !empty;

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.accept) begin
      op_q  <= op_i;
      val_q <= value_i;
    end
    if (cmd_i.emit) begin
      out_top_q <= ne ? top_q : '0;
      out_ne_q  <= ne;
      out_err_q <= err_q;
      out_ans_q <= (err_q || !ne) ? '1 : {1'b0, top_q};
    end
  end

  assign top_value_o = out_top_q;
  assign not_empty_o = out_ne_q;
  assign error_o     = out_err_q;
  assign answer_o    = out_ans_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(bswm_pkg::DEPTH))
    else $error("stack count beyond depth");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && restart_i) |=> (cnt_q == '0 && !err_q))
    else $error("restart did not empty the stack");
  a_emit_ne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_ne_q == (cnt_q != '0)))
    else $error("reported non-empty flag disagrees with count");
  a_emit_err_ans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (!out_err_q || out_ans_q == '1))
    else $error("answer not all ones with error set");

endmodule
`default_nettype wire

/* hw/rtl/bounded_stack_word_machine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stack_word_machine
// Reverse-Polish stack evaluator: push, duplicate, pop, add, subtract over
// unsigned words, reporting top, non-empty, sticky error and answer per item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | op_i, value_i, restart_i
//   out     | output    | out_valid_o/out_ready_i | top_value_o, not_empty_o,
//           |           |                         | error_o, answer_o
//
// One item at a time. Push, duplicate, failed ops, unused codes and a pop that
// empties the stack go from exec straight to finish; a pop with an entry
// left below adds a load step and add/subtract an operand step because the
// stack memory has one registered read port; a rejected sum or difference with
// operands left below adds a load step too (second read to refresh the cached top).
// in_ready_o is high only when the sequencer is idle; a result waiting in the
// output register does not block the next transfer, but a stalled output
// holds the following result in its last step. Reset clears the count and the
// error flag at once; the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module bounded_stack_word_machine (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [bswm_pkg::OP_BITS-1:0]        op_i,
  input  wire logic [bswm_pkg::IN_BITS-1:0]        value_i,
  input  wire logic                                restart_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [bswm_pkg::VALUE_BITS-1:0]          top_value_o,
  output logic                                     not_empty_o,
  output logic                                     error_o,
  output logic signed [bswm_pkg::ANS_BITS-1:0]     answer_o
);

  bswm_pkg::cmd_t  cmd;
  bswm_pkg::stat_t stat;

  // sequencer: step an item through exec, operand fetch and top reload
  bswm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // stack memory with the top cached in a register, plus the result register
  bswm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .value_i     (value_i),
    .restart_i   (restart_i),
    .top_value_o (top_value_o),
    .not_empty_o (not_empty_o),
    .error_o     (error_o),
    .answer_o    (answer_o)
  );

endmodule
`default_nettype wire

/* verif/tb_bounded_stack_word_machine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_stack_word_machine
// Self-checking bench for the stack evaluator. A built-in stack predictor
// tracks every accepted operation and queues the report it should cause. A
// monitor pops and compares each report field by field. Directed corners,
// a fill to full depth and long random runs are exercised under four
// handshake idling regimes.
// ----------------------------------------------------------------------------
module tb_bounded_stack_word_machine;

  localparam int unsigned VB    = bswm_pkg::VALUE_BITS;
  localparam int unsigned IB    = bswm_pkg::IN_BITS;
  localparam int unsigned OB    = bswm_pkg::OP_BITS;
  localparam int unsigned NB    = bswm_pkg::ANS_BITS;
  localparam int unsigned DEPTH = bswm_pkg::DEPTH;

  localparam logic [IB-1:0] VAL_MAX = IB'((64'd1 << VB) - 1);
  localparam int unsigned   N_OPS   = 2 ** OB;

  // One report as the block presents it after each operation.
  typedef struct packed {
    logic [VB-1:0] top;
    logic          not_empty;
    logic          error;
    logic [NB-1:0] answer;
  } report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OB-1:0]        op_i;
  logic [IB-1:0]        value_i;
  logic                 restart_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [VB-1:0]        top_value_o;
  logic                 not_empty_o;
  logic                 error_o;
  logic signed [NB-1:0] answer_o;

  bounded_stack_word_machine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .top_value_o (top_value_o),
    .not_empty_o (not_empty_o),
    .error_o     (error_o),
    .answer_o    (answer_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Stack predictor: private copy of the stack, its depth and the sticky flag.
  // --------------------------------------------------------------------------
  logic [VB-1:0] shadow_stack [DEPTH];
  int unsigned   shadow_depth = 0;
  bit            shadow_error = 1'b0;
  report_t       pending_reports [$];

  // Coverage tallies for the closing summary.
  int unsigned peak_depth     = 0;
  int unsigned hits_underflow = 0;
  int unsigned hits_overflow  = 0;
  int unsigned hits_bad_push  = 0;
  int unsigned hits_range     = 0;
  int unsigned hits_restart   = 0;

  int unsigned items_sent     = 0;
  int unsigned reports_seen   = 0;
  int unsigned mismatch_count = 0;

  // Knobs for the handshake idling, in percent per cycle.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Push onto the shadow stack; a full stack flags overflow and keeps its contents.
  task automatic shadow_push(input logic [VB-1:0] v);
    if (shadow_depth >= DEPTH) begin
      shadow_error = 1'b1;
      hits_overflow++;
    end else begin
      shadow_stack[shadow_depth] = v;
      shadow_depth++;
      if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    end
  endtask

  // Apply one accepted operation and queue the report it must produce.
  task automatic apply_stack_op(input logic [OB-1:0] op, input logic [IB-1:0] val,
                                input logic rs);
    logic [VB-1:0] a;
    logic [VB-1:0] b;
    logic [VB:0]   sum;
    report_t       rpt;
    if (rs) begin
      shadow_depth = 0;
      shadow_error = 1'b0;
      hits_restart++;
    end
    case (op)
      bswm_pkg::OP_PUSH: begin
        if (val > VAL_MAX) begin
          shadow_error = 1'b1;
          hits_bad_push++;
        end else begin
          shadow_push(val[VB-1:0]);
        end
      end
      bswm_pkg::OP_DUP: begin
        if (shadow_depth == 0) begin
          shadow_error = 1'b1;
          hits_underflow++;
        end else begin
          shadow_push(shadow_stack[shadow_depth-1]);
        end
      end
      bswm_pkg::OP_POP: begin
        if (shadow_depth == 0) begin
          shadow_error = 1'b1;
          hits_underflow++;
        end else begin
          shadow_depth--;
        end
      end
      bswm_pkg::OP_ADD, bswm_pkg::OP_SUB: begin
        if (shadow_depth < 2) begin
          shadow_error = 1'b1;
          hits_underflow++;
        end else begin
          // Both operands leave the stack even when the result is rejected.
          a = shadow_stack[shadow_depth-1];
          b = shadow_stack[shadow_depth-2];
          shadow_depth -= 2;
          if (op == bswm_pkg::OP_SUB) begin
            if (a < b) begin
              shadow_error = 1'b1;
              hits_range++;
            end else begin
              shadow_push(a - b);
            end
          end else begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum > VAL_MAX) begin
              shadow_error = 1'b1;
              hits_range++;
            end else begin
              shadow_push(sum[VB-1:0]);
            end
          end
        end
      end
      default: ;  // spare codes: report only
    endcase
    rpt.not_empty = (shadow_depth != 0);
    rpt.top       = rpt.not_empty ? shadow_stack[shadow_depth-1] : '0;
    rpt.error     = shadow_error;
    rpt.answer    = (shadow_error || !rpt.not_empty) ? '1 : {1'b0, rpt.top};
    pending_reports.insert(pending_reports.size(), rpt);
  endtask

  // --------------------------------------------------------------------------
  // Input side: one transfer per call, with optional idle cycles in front.
  // Valid is only lowered when a gap follows, so it never drops and rises in
  // one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [OB-1:0] op, input logic [IB-1:0] val,
                           input logic rs);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 24) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    restart_i  <= rs;
    // Hold the item until the block takes it.
    do @(posedge clk_i); while (!in_ready_o);
    apply_stack_op(op, val, rs);
    items_sent++;
  endtask

  // Drop valid, wait for every queued report, then let the pipeline settle
  // so a stray extra report would still be caught.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure, and the report checker.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: report with none expected, got top %0d error %0b answer %0d",
                 $time, top_value_o, error_o, answer_o);
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        check_field("top_value", longint'(want.top), longint'(top_value_o));
        check_field("not_empty", longint'(want.not_empty), longint'(not_empty_o));
        check_field("error", longint'(want.error), longint'(error_o));
        check_field("answer", longint'($signed(want.answer)), longint'(answer_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short directed list: every operation, the field extremes and each error path but overflow.
  task automatic test_directed_corners();
    send_item(bswm_pkg::OP_POP, 32'd0, 1'b1);          // underflow on empty stack
    send_item(bswm_pkg::OP_PUSH, 32'd0, 1'b1);         // restart clears the flag
    send_item(bswm_pkg::OP_PUSH, VAL_MAX, 1'b0);
    send_item(bswm_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);  // largest legal sum
    send_item(bswm_pkg::OP_PUSH, 32'd1, 1'b0);
    send_item(bswm_pkg::OP_ADD, 32'd0, 1'b0);          // sum too big, operands consumed
    send_item(bswm_pkg::OP_PUSH, VAL_MAX + 1, 1'b1);   // just out of range
    send_item(bswm_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0); // widest value
    send_item(bswm_pkg::OP_PUSH, 32'd9, 1'b1);
    send_item(bswm_pkg::OP_PUSH, 32'd5, 1'b0);
    send_item(bswm_pkg::OP_PUSH, 32'd3, 1'b0);
    send_item(bswm_pkg::OP_SUB, 32'd0, 1'b0);          // negative difference, one left below
    send_item(bswm_pkg::OP_PUSH, 32'd3, 1'b1);
    send_item(bswm_pkg::OP_PUSH, 32'd5, 1'b0);
    send_item(bswm_pkg::OP_SUB, 32'd0, 1'b0);          // 5 - 3
    send_item(bswm_pkg::OP_DUP, 32'd0, 1'b0);
    send_item(bswm_pkg::OP_SUB, 32'd0, 1'b0);          // zero difference is fine
    send_item(bswm_pkg::OP_POP, 32'd0, 1'b0);
    send_item(bswm_pkg::OP_DUP, 32'd0, 1'b0);          // dup on empty
    send_item(bswm_pkg::OP_PUSH, 32'd7, 1'b1);
    send_item(bswm_pkg::OP_ADD, 32'd0, 1'b0);          // only one operand
    for (int c = int'(bswm_pkg::OP_SUB) + 1; c < N_OPS; c++) begin
      send_item(c[OB-1:0], $urandom, 1'b0);
    end
    send_item(bswm_pkg::OP_POP, 32'd0, 1'b1);          // restart then pop on emptied stack
    drain_reports();
  endtask

  // Fill to full depth, hit overflow with push and dup, then fold back down.
  task automatic test_depth_limit();
    send_item(bswm_pkg::OP_PUSH, $urandom_range(1000), 1'b1);
    for (int k = 1; k < DEPTH; k++) begin
      send_item(bswm_pkg::OP_PUSH, $urandom_range(VAL_MAX >> 7), 1'b0);
    end
    send_item(bswm_pkg::OP_PUSH, 32'd1, 1'b0);
    send_item(bswm_pkg::OP_DUP, 32'd0, 1'b0);
    for (int k = 0; k < 24; k++) begin
      send_item(k[0] ? bswm_pkg::OP_SUB : bswm_pkg::OP_ADD, $urandom, 1'b0);
    end
    send_item(bswm_pkg::OP_DUP, 32'd0, 1'b1);          // restart on a full run of work
    drain_reports();
  endtask

  function automatic logic [IB-1:0] pick_push_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VAL_MAX;
      2, 3:    return $urandom_range(VAL_MAX);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Mostly well-formed programs driven by the predicted depth, plus noise.
  task automatic test_random_program(input int unsigned n_items);
    int unsigned   push_bias;
    int unsigned   r;
    int unsigned   eff_depth;
    logic [OB-1:0] op;
    logic [IB-1:0] val;
    logic          rs;
    push_bias = 55;
    for (int unsigned i = 0; i < n_items; i++) begin
      // Vary the drift so some stretches climb to the ceiling and some hover.
      if (i % 64 == 0) push_bias = $urandom_range(35, 75);
      rs = (shadow_error && $urandom_range(99) < 8) || ($urandom_range(99) < 2);
      eff_depth = rs ? 0 : shadow_depth;
      val = $urandom;
      if ($urandom_range(99) < 12) begin
        op = OB'($urandom_range(N_OPS - 1));
        if ($urandom_range(1) == 0) val = pick_push_value();
      end else begin
        r = $urandom_range(99);
        if (eff_depth < 2 || r < push_bias) begin
          if (eff_depth != 0 && $urandom_range(3) == 0) begin
            op = bswm_pkg::OP_DUP;
          end else begin
            op  = bswm_pkg::OP_PUSH;
            val = pick_push_value();
          end
        end else if (r < push_bias + 12) begin
          op = bswm_pkg::OP_POP;
        end else begin
          op = $urandom_range(1) ? bswm_pkg::OP_SUB : bswm_pkg::OP_ADD;
        end
      end
      send_item(op, val, rs);
    end
    drain_reports();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= bswm_pkg::OP_PUSH;
    value_i    <= '0;
    restart_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_depth_limit();

    // No idling, then sender gaps, then receiver stalls, then light both.
    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_program(235);
    send_idle_pct = 54; recv_stall_pct = 0;
    test_random_program(235);
    send_idle_pct = 0;  recv_stall_pct = 54;
    test_random_program(235);
    send_idle_pct = 6;  recv_stall_pct = 6;
    test_random_program(235);

    $display("Ran %0d operations, checked %0d reports; stack reached %0d of %0d entries.",
             items_sent, reports_seen, peak_depth, DEPTH);
    $display("Errors provoked: %0d underflow, %0d overflow, %0d bad push, %0d sum/diff;",
             hits_underflow, hits_overflow, hits_bad_push, hits_range);
    $display("  %0d restarts.", hits_restart);
    if (mismatch_count == 0) begin
      $display("** bounded_stack_word_machine: PASSED **");
    end else begin
      $display("** bounded_stack_word_machine: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3ms;
    $display("%0t: run did not complete, %0d reports still pending", $time,
             pending_reports.size());
    $display("** bounded_stack_word_machine: FAILED **");
    $finish;
  end

endmodule
